// ===== hw/rtl/first_fit_freelist_allocator_assert.svh =====
// Assertion macros used by the checker file of the allocator.
`ifndef FIRST_FIT_FREELIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREELIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ffa_pkg.sv =====
// Package with the transaction types and defaults of the first-fit allocator.
package ffa_pkg;

  localparam int unsigned ARENA_BYTES_DEF  = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned ADJ_W            = 8;

  typedef struct packed {
    logic        action;
    logic [12:0] request_size;
    logic [2:0]  align_log2;
    logic [11:0] block_address;
    logic        is_null;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] result_address;
    logic [12:0] used_bytes;
    logic [8:0]  live_count;
  } rsp_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_cmd_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

endpackage

// ===== hw/rtl/ffa_adjust.sv =====
// Forward adjustment of a free node start: aligned address with room for a header.
module ffa_adjust #(
  parameter int unsigned HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int unsigned PW           = 13
) (
  input  logic [PW-1:0]              node_i,
  input  logic [2:0]                 align_log2_i,
  output logic [ffa_pkg::ADJ_W-1:0]  adj_o
);

  localparam logic [8:0] Hdr = 9'(HEADER_BYTES);

  logic [7:0] align;
  logic [7:0] mask;
  logic [7:0] low;
  logic [7:0] base;
  logic [8:0] need;
  logic [8:0] ceil_sum;
  logic [8:0] pad;
  logic [8:0] sum;

  always_comb begin
    align    = 8'd1 << align_log2_i;
    mask     = align - 8'd1;
    low      = {1'b0, node_i[6:0]} & mask;
    base     = (align - low) & mask;
    need     = Hdr - {1'b0, base};
    ceil_sum = (need + {1'b0, mask}) >> align_log2_i;
    pad      = ceil_sum << align_log2_i;
    sum      = {1'b0, base} + pad;
    if ({1'b0, base} < Hdr) begin
      adj_o = sum[7:0];
    end else begin
      adj_o = base;
    end
  end

endmodule

// ===== hw/rtl/ffa_node_mem.sv =====
// Node store: one {size, link} word per arena offset, one access per cycle.
module ffa_node_mem #(
  parameter int unsigned ARENA_BYTES = ffa_pkg::ARENA_BYTES_DEF,
  parameter int unsigned AW          = 12,
  parameter int unsigned PW          = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffa_pkg::mem_cmd_t cmd_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [2*PW-1:0]   wdata_i,
  output logic [2*PW-1:0]   rdata_o
);

  localparam logic [2*PW-1:0] ResetEntry = {PW'(ARENA_BYTES), PW'(ARENA_BYTES)};

  logic [2*PW-1:0] mem_q [ARENA_BYTES];
  logic [2*PW-1:0] rdata_q;
  logic            init0_q;
  logic            sel0_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (cmd_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  // Entry 0 holds the whole arena after reset until it is first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init0_q <= 1'b1;
      sel0_q  <= 1'b0;
    end else begin
      if (cmd_i.we && (addr_i == '0)) begin
        init0_q <= 1'b0;
      end
      if (cmd_i.re) begin
        sel0_q <= (addr_i == '0) && init0_q;
      end
    end
  end

  assign rdata_o = sel0_q ? ResetEntry : rdata_q;

endmodule

// ===== hw/rtl/ffa_ctrl.sv =====
// Sequencer that walks the free list and edits nodes through the node store.
module ffa_ctrl #(
  parameter int unsigned ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int unsigned AW           = 12,
  parameter int unsigned PW           = 13
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ffa_pkg::req_t     req_i,
  output logic              busy_o,
  output logic              rsp_valid_o,
  output ffa_pkg::rsp_t     rsp_o,
  output ffa_pkg::mem_cmd_t mem_cmd_o,
  output logic [AW-1:0]     mem_addr_o,
  output logic [2*PW-1:0]   mem_wdata_o,
  input  logic [2*PW-1:0]   mem_rdata_i
);

  localparam int unsigned   XW     = ((PW > 13) ? PW : 13) + 2;
  localparam logic [PW-1:0] PtrEnd = PW'(ARENA_BYTES);
  localparam logic [XW-1:0] XEnd   = XW'(ARENA_BYTES);
  localparam logic [XW-1:0] XHdr   = XW'(HEADER_BYTES);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_A_RD  = 14'b00000000000010,
    S_A_EV  = 14'b00000000000100,
    S_A_LNK = 14'b00000000001000,
    S_A_HDR = 14'b00000000010000,
    S_F_HRD = 14'b00000000100000,
    S_F_HEV = 14'b00000001000000,
    S_F_RD  = 14'b00000010000000,
    S_F_EV  = 14'b00000100000000,
    S_F_INS = 14'b00001000000000,
    S_F_IN2 = 14'b00010000000000,
    S_F_MRG = 14'b00100000000000,
    S_F_NEV = 14'b01000000000000,
    S_RESP  = 14'b10000000000000
  } state_e;

  function automatic logic [XW-1:0] zx(input logic [PW-1:0] v);
    return {{(XW-PW){1'b0}}, v};
  endfunction

  function automatic logic in_arena(input logic [XW-1:0] v);
    return !v[XW-1] && (v < XEnd);
  endfunction

  function automatic logic [PW-1:0] sat_ptr(input logic [XW-1:0] v);
    return in_arena(v) ? v[PW-1:0] : PtrEnd;
  endfunction

  state_e state_q, state_d;
  logic [PW-1:0] free_head_q, free_head_d;
  logic [12:0]   used_q, used_d;
  logic [8:0]    count_q, count_d;

  ffa_pkg::req_t req_q, req_d;
  logic [PW-1:0] node_q, node_d;
  logic [PW-1:0] prev_q, prev_d;
  logic [PW-1:0] prev_size_q, prev_size_d;
  logic [PW-1:0] prev_link_q, prev_link_d;
  logic          has_prev_q, has_prev_d;
  logic [PW-1:0] steps_q, steps_d;
  logic [ffa_pkg::ADJ_W-1:0] adj_q, adj_d;
  logic [PW-1:0] total_q, total_d;
  logic [PW-1:0] follow_q, follow_d;
  logic [PW-1:0] bsize_q, bsize_d;
  logic [XW-1:0] start_q, start_d;
  logic [XW-1:0] end_q, end_d;
  logic [XW-1:0] cur_q, cur_d;
  logic [PW-1:0] cur_size_q, cur_size_d;
  logic          hdr_oob_q, hdr_oob_d;
  logic          ok_q, ok_d;
  logic [11:0]   addr_q, addr_d;

  logic [ffa_pkg::ADJ_W-1:0] adj;
  logic [PW-1:0] rd_size;
  logic [PW-1:0] rd_link;
  logic [XW-1:0] px;
  logic [XW-1:0] px_in;
  logic [XW-1:0] tot;
  logic [XW-1:0] rem;
  logic [XW-1:0] fol;
  logic [XW-1:0] hx;
  logic [XW-1:0] ax;
  logic [XW-1:0] adj_x;
  logic [PW-1:0] hsize;
  logic [PW-1:0] hlink;
  logic [XW-1:0] new_start;
  logic          ge_end;
  logic          at_end;

  ffa_adjust #(
    .HEADER_BYTES(HEADER_BYTES),
    .PW          (PW)
  ) u_adjust (
    .node_i      (node_q),
    .align_log2_i(req_q.align_log2),
    .adj_o       (adj)
  );

  assign rd_size = mem_rdata_i[2*PW-1:PW];
  assign rd_link = mem_rdata_i[PW-1:0];
  assign px      = {{(XW-12){1'b0}}, req_q.block_address};
  assign px_in   = {{(XW-12){1'b0}}, req_i.block_address};
  assign adj_x   = {{(XW-ffa_pkg::ADJ_W){1'b0}}, adj_q};
  assign tot     = {{(XW-13){1'b0}}, req_q.request_size} + adj_x;
  assign rem     = zx(rd_size) - tot;
  assign fol     = zx(node_q) + tot;
  assign hx      = zx(node_q) + adj_x - XHdr;
  assign ax      = zx(node_q) + adj_x;
  assign ge_end  = !end_q[XW-1] && (zx(node_q) >= end_q);
  assign at_end  = (node_q < PtrEnd) && !end_q[XW-1] && (zx(node_q) == end_q);
  assign hsize   = hdr_oob_q ? '0 : rd_size;
  assign hlink   = hdr_oob_q ? PtrEnd : rd_link;
  assign new_start = px - zx(hlink);

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = '{ok: ok_q, result_address: addr_q, used_bytes: used_q,
                         live_count: count_q};

  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    used_d      = used_q;
    count_d     = count_q;
    req_d       = req_q;
    node_d      = node_q;
    prev_d      = prev_q;
    prev_size_d = prev_size_q;
    prev_link_d = prev_link_q;
    has_prev_d  = has_prev_q;
    steps_d     = steps_q;
    adj_d       = adj_q;
    total_d     = total_q;
    follow_d    = follow_q;
    bsize_d     = bsize_q;
    start_d     = start_q;
    end_d       = end_q;
    cur_d       = cur_q;
    cur_size_d  = cur_size_q;
    hdr_oob_d   = hdr_oob_q;
    ok_d        = ok_q;
    addr_d      = addr_q;
    mem_cmd_o   = '{re: 1'b0, we: 1'b0};
    mem_addr_o  = node_q[AW-1:0];
    mem_wdata_o = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d      = req_i;
          node_d     = free_head_q;
          has_prev_d = 1'b0;
          steps_d    = '0;
          ok_d       = 1'b1;
          addr_d     = '0;
          if (req_i.action == ffa_pkg::ACT_ALLOC) begin
            state_d = S_A_RD;
          end else if (req_i.is_null) begin
            state_d = S_RESP;
          end else if (px_in < XHdr) begin
            bsize_d = '0;
            start_d = px_in;
            end_d   = px_in;
            state_d = S_F_RD;
          end else begin
            state_d = S_F_HRD;
          end
        end
      end
      S_A_RD: begin
        adj_d = adj;
        if ((node_q >= PtrEnd) || (steps_q == PtrEnd)) begin
          ok_d    = 1'b0;
          addr_d  = '0;
          state_d = S_RESP;
        end else begin
          mem_cmd_o.re = 1'b1;
          mem_addr_o   = node_q[AW-1:0];
          state_d      = S_A_EV;
        end
      end
      S_A_EV: begin
        if (zx(rd_size) < tot) begin
          prev_d      = node_q;
          prev_size_d = rd_size;
          has_prev_d  = 1'b1;
          node_d      = rd_link;
          steps_d     = steps_q + 1'b1;
          state_d     = S_A_RD;
        end else begin
          if (rem <= XHdr) begin
            total_d  = rd_size;
            follow_d = rd_link;
          end else begin
            total_d  = tot[PW-1:0];
            follow_d = sat_ptr(fol);
            if (in_arena(fol)) begin
              mem_cmd_o.we = 1'b1;
              mem_addr_o   = fol[AW-1:0];
              mem_wdata_o  = {rem[PW-1:0], rd_link};
            end
          end
          state_d = S_A_LNK;
        end
      end
      S_A_LNK: begin
        if (has_prev_q) begin
          mem_cmd_o.we = 1'b1;
          mem_addr_o   = prev_q[AW-1:0];
          mem_wdata_o  = {prev_size_q, follow_q};
        end else begin
          free_head_d = follow_q;
        end
        state_d = S_A_HDR;
      end
      S_A_HDR: begin
        if (in_arena(hx)) begin
          mem_cmd_o.we = 1'b1;
          mem_addr_o   = hx[AW-1:0];
          mem_wdata_o  = {total_q, {{(PW-ffa_pkg::ADJ_W){1'b0}}, adj_q}};
        end
        used_d  = used_q + 13'(total_q);
        count_d = count_q + 9'd1;
        ok_d    = 1'b1;
        addr_d  = ax[11:0];
        state_d = S_RESP;
      end
      S_F_HRD: begin
        hdr_oob_d = !in_arena(px - XHdr);
        if (in_arena(px - XHdr)) begin
          mem_cmd_o.re = 1'b1;
          mem_addr_o   = px[AW-1:0] - AW'(HEADER_BYTES);
        end
        state_d = S_F_HEV;
      end
      S_F_HEV: begin
        bsize_d = hsize;
        start_d = new_start;
        end_d   = new_start + zx(hsize);
        state_d = S_F_RD;
      end
      S_F_RD: begin
        if ((node_q >= PtrEnd) || (steps_q == PtrEnd) || ge_end) begin
          state_d = S_F_INS;
        end else begin
          mem_cmd_o.re = 1'b1;
          mem_addr_o   = node_q[AW-1:0];
          state_d      = S_F_EV;
        end
      end
      S_F_EV: begin
        prev_d      = node_q;
        prev_size_d = rd_size;
        prev_link_d = rd_link;
        has_prev_d  = 1'b1;
        node_d      = rd_link;
        steps_d     = steps_q + 1'b1;
        state_d     = S_F_RD;
      end
      S_F_INS: begin
        if (!has_prev_q) begin
          if (in_arena(start_q)) begin
            mem_cmd_o.we = 1'b1;
            mem_addr_o   = start_q[AW-1:0];
            mem_wdata_o  = {bsize_q, free_head_q};
          end
          free_head_d = sat_ptr(start_q);
          cur_d       = start_q;
          cur_size_d  = bsize_q;
          state_d     = S_F_MRG;
        end else if ((zx(prev_q) + zx(prev_size_q)) == start_q) begin
          mem_cmd_o.we = 1'b1;
          mem_addr_o   = prev_q[AW-1:0];
          mem_wdata_o  = {prev_size_q + bsize_q, prev_link_q};
          cur_d        = zx(prev_q);
          cur_size_d   = prev_size_q + bsize_q;
          state_d      = S_F_MRG;
        end else begin
          if (in_arena(start_q)) begin
            mem_cmd_o.we = 1'b1;
            mem_addr_o   = start_q[AW-1:0];
            mem_wdata_o  = {bsize_q, prev_link_q};
          end
          cur_d      = start_q;
          cur_size_d = bsize_q;
          state_d    = S_F_IN2;
        end
      end
      S_F_IN2: begin
        // Relink the predecessor; if it is the freed block itself its size is new.
        mem_cmd_o.we = 1'b1;
        mem_addr_o   = prev_q[AW-1:0];
        mem_wdata_o  = {(zx(prev_q) == start_q) ? bsize_q : prev_size_q,
                        sat_ptr(start_q)};
        state_d      = S_F_MRG;
      end
      S_F_MRG: begin
        if (at_end) begin
          mem_cmd_o.re = 1'b1;
          mem_addr_o   = node_q[AW-1:0];
          state_d      = S_F_NEV;
        end else begin
          used_d  = used_q - 13'(bsize_q);
          count_d = count_q - 9'd1;
          state_d = S_RESP;
        end
      end
      S_F_NEV: begin
        if (in_arena(cur_q)) begin
          mem_cmd_o.we = 1'b1;
          mem_addr_o   = cur_q[AW-1:0];
          mem_wdata_o  = {cur_size_q + rd_size, rd_link};
        end
        used_d  = used_q - 13'(bsize_q);
        count_d = count_q - 9'd1;
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      used_q      <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      used_q      <= used_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    node_q      <= node_d;
    prev_q      <= prev_d;
    prev_size_q <= prev_size_d;
    prev_link_q <= prev_link_d;
    has_prev_q  <= has_prev_d;
    steps_q     <= steps_d;
    adj_q       <= adj_d;
    total_q     <= total_d;
    follow_q    <= follow_d;
    bsize_q     <= bsize_d;
    start_q     <= start_d;
    end_q       <= end_d;
    cur_q       <= cur_d;
    cur_size_q  <= cur_size_d;
    hdr_oob_q   <= hdr_oob_d;
    ok_q        <= ok_d;
    addr_q      <= addr_d;
  end

endmodule

// ===== hw/rtl/first_fit_freelist_allocator.sv =====
// Top level of the first-fit free-list allocator with coalescing.
//
//   Channel    Signals               Direction  Handshake
//   request    start, busy, req_i    in         taken when start is high and busy is low
//   response   done_o, rsp_o         out        shown for one cycle, cannot be held off
//
// Each node is visited in a read state and an evaluate state on the single node store port.
// An allocate walks the list until a node fits, then relinks it and writes the header; a
// failed one answers when the walk ends. A free reads the block header (not for an address
// below the header size), walks up to the block, inserts it and merges; a null free answers
// at once. The strobe comes in the first cycle with busy low; the receiver cannot stall.
// Reset clears the list head and counts and marks node 0 as the whole arena at once.
module first_fit_freelist_allocator #(
  parameter int unsigned ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ffa_pkg::req_t req_i,
  output logic          done_o,
  output ffa_pkg::rsp_t rsp_o
);

  // Node store index width and pointer width; a pointer can also hold the
  // arena size, which marks the end of the list.
  localparam int unsigned AW = $clog2(ARENA_BYTES);
  localparam int unsigned PW = $clog2(ARENA_BYTES + 1);

  ffa_pkg::mem_cmd_t mem_cmd;
  logic [AW-1:0]     mem_addr;
  logic [2*PW-1:0]   mem_wdata;
  logic [2*PW-1:0]   mem_rdata;
  logic              rsp_valid;
  ffa_pkg::rsp_t     rsp;
  logic              done_q;
  ffa_pkg::rsp_t     rsp_q;

  // The sequencer owns the list walk and every read-modify-write of a node.
  // It never reads and writes the same cycle, so no forwarding is needed.
  ffa_ctrl #(
    .ARENA_BYTES (ARENA_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .AW          (AW),
    .PW          (PW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req_i),
    .busy_o     (busy),
    .rsp_valid_o(rsp_valid),
    .rsp_o      (rsp),
    .mem_cmd_o  (mem_cmd),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  ffa_node_mem #(
    .ARENA_BYTES(ARENA_BYTES),
    .AW         (AW),
    .PW         (PW)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mem_cmd),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Output register: the response transaction is presented for exactly one
  // cycle while the sequencer is already free for the next request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid) begin
      rsp_q <= rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== hw/rtl/ffa_checker.sv =====
// Port-level checker for the allocator and its bind to the top level.
`include "first_fit_freelist_allocator_assert.svh"

module ffa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input ffa_pkg::rsp_t rsp_o
);

  `FFA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `FFA_ASSERT_IMP(a_done_after_busy, done_o, $past(busy), "response without a busy cycle")
  `FFA_ASSERT_NXT(a_done_single, done_o, !done_o, "response strobe lasted two cycles")
  `FFA_ASSERT_IMP(a_fail_addr, done_o && !rsp_o.ok, rsp_o.result_address == 12'd0,
                  "failed allocate returned an address")

endmodule

bind first_fit_freelist_allocator ffa_checker u_ffa_checker (.*);
